[src/blocked_modular_prefix_sum_assert.svh]
// Assertion macros used by the checker file.
`ifndef BLOCKED_MODULAR_PREFIX_SUM_ASSERT_SVH
`define BLOCKED_MODULAR_PREFIX_SUM_ASSERT_SVH

// Same-cycle implication, disabled while rst_n is low.
`define BMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while rst_n is low.
`define BMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/bmps_pkg.sv]
`default_nettype none

package bmps_pkg;

    localparam int POS_W = 13;
    localparam int VAL_W = 30;

    localparam int BLOCK_SIZE_DEF = 64;
    localparam int NUM_BLOCKS_DEF = 64;
    localparam int CFG_RESET      = 4096;

    localparam logic [VAL_W-1:0] PRIME = VAL_W'(1000000007);

    // Divider result, handed from the divider to the sequencer.
    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quot;
        logic [POS_W-1:0] rem;
    } div_res_t;

    // Both operands below the prime.
    function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME}) begin
            s = s - {1'b0, PRIME};
        end
        return s[VAL_W-1:0];
    endfunction

    // Any 30-bit value is below twice the prime.
    function automatic logic [VAL_W-1:0] mod_reduce(input logic [VAL_W-1:0] a);
        logic [VAL_W-1:0] r;
        r = a;
        if (a >= PRIME) begin
            r = a - PRIME;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/bmps_ram.sv]
`default_nettype none

module bmps_ram #(
    parameter  int WIDTH  = 30,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/bmps_div.sv]
`default_nettype none

// Division by a constant through a reciprocal multiply: the quotient is registered
// first, then the remainder is registered from the registered quotient.
module bmps_div #(
    parameter int DIVISOR = bmps_pkg::BLOCK_SIZE_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [bmps_pkg::POS_W-1:0] dividend,
    output bmps_pkg::div_res_t              res
);

    import bmps_pkg::*;

    // Shift by POS_W + ceil(log2(DIVISOR)) with the multiplier rounded up:
    // exact for every POS_W-bit dividend.
    localparam int SHIFT  = POS_W + $clog2(DIVISOR);
    localparam int PROD_W = 2 * POS_W + 1;
    localparam int BACK_W = 2 * POS_W;

    localparam logic [POS_W:0]   RECIP = (POS_W + 1)'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                                      / 64'(DIVISOR));
    localparam logic [POS_W-1:0] DIV_C = POS_W'(DIVISOR);

    logic              stage_reg, stage_next;
    logic              done_reg, done_next;
    logic [POS_W-1:0]  dvd_reg, dvd_next;
    logic [POS_W-1:0]  quot_reg, quot_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0] prod;
    logic [BACK_W-1:0] back;

    always_comb begin
        prod       = PROD_W'(dividend) * PROD_W'(RECIP);
        back       = BACK_W'(quot_reg) * BACK_W'(DIV_C);
        stage_next = start;
        done_next  = stage_reg;
        dvd_next   = dvd_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        if (start) begin
            dvd_next  = dividend;
            quot_next = POS_W'(prod >> SHIFT);
        end
        // Remainder is below the divisor, so the low bits suffice.
        if (stage_reg) begin
            rem_next = dvd_reg - back[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

`default_nettype wire

[src/blocked_modular_prefix_sum.sv]
// Blocked prefix-sum store modulo 1000000007 over positions 1..BLOCK_SIZE*NUM_BLOCKS.
// Input channel (s_valid/s_ready): s_mode 0 adds s_value at s_position, s_mode 1
// queries the prefix sum up to s_position. Only queries produce a transaction on
// the result channel (m_valid/m_ready, m_prefix_sum). cfg_wr_en/cfg_wr_data set
// positions_in_use, which bounds the block offsets that an add updates.
// One item is worked on at a time; s_ready is high only while the sequencer idles.
// Sequence: the position is split into block and in-block index by a reciprocal
// multiply. A valid query then reads both memories, sums and loads the output
// register. A query at position zero or beyond capacity skips these steps and
// loads a zero result. An add walks the partial sums from its in-block index to
// the block end and then the offsets of the later blocks in use, with one
// read-modify-write per cycle on each memory, and ends in a drain state. An add
// with an invalid position is dropped at once.
// Reset: a clearing pass writes zero to all BLOCK_SIZE*NUM_BLOCKS entries, one a
// cycle; s_ready stays low until it ends, while configuration writes are taken
// throughout.
// Stall: a result waits in the output register; the next item is accepted
// meanwhile, and only the next result waits for the register to drain.
`default_nettype none

module blocked_modular_prefix_sum #(
    parameter int BLOCK_SIZE = bmps_pkg::BLOCK_SIZE_DEF,
    parameter int NUM_BLOCKS = bmps_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [bmps_pkg::POS_W-1:0] cfg_wr_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_mode,
    input  wire logic [bmps_pkg::POS_W-1:0] s_position,
    input  wire logic [bmps_pkg::VAL_W-1:0] s_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [bmps_pkg::VAL_W-1:0] m_prefix_sum
);

    import bmps_pkg::*;

    localparam int CAP    = BLOCK_SIZE * NUM_BLOCKS;
    localparam int PS_AW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int OB_AW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OB_CW  = $clog2(NUM_BLOCKS + 1);
    localparam int BASE_W = $clog2(CAP + 1) + 1;

    localparam logic [31:0]       CAP32    = 32'(CAP);
    localparam logic [31:0]       NB32     = 32'(NUM_BLOCKS);
    localparam logic [PS_AW-1:0]  CLR_LAST = PS_AW'(CAP - 1);
    localparam logic [PS_AW-1:0]  PS_ONE   = PS_AW'(1);
    localparam logic [POS_W-1:0]  IDX_LAST = POS_W'(BLOCK_SIZE - 1);
    localparam logic [POS_W-1:0]  POS_ONE  = POS_W'(1);
    localparam logic [BASE_W-1:0] BS_B     = BASE_W'(BLOCK_SIZE);
    localparam logic [OB_CW-1:0]  NB_C     = OB_CW'(NUM_BLOCKS);
    localparam logic [OB_CW-1:0]  OB_ONE   = OB_CW'(1);

    // Sequencer state codes.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_QRD   = 4'd3;
    localparam logic [3:0] S_QSUM  = 4'd4;
    localparam logic [3:0] S_QOUT  = 4'd5;
    localparam logic [3:0] S_APS   = 4'd6;
    localparam logic [3:0] S_AOFF  = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Control registers.
    logic [3:0]       state_reg, state_next;
    logic [POS_W-1:0] cfg_reg, cfg_next;
    logic [PS_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic             ps_wb_reg, ps_wb_next;
    logic             off_wb_reg, off_wb_next;
    logic             m_valid_reg, m_valid_next;

    // Item and walk registers.
    logic              mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [PS_AW-1:0]  ps_addr_reg, ps_addr_next;
    logic [POS_W-1:0]  idx_reg, idx_next;
    logic [OB_CW-1:0]  ob_cnt_reg, ob_cnt_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [PS_AW-1:0]  ps_wb_addr_reg, ps_wb_addr_next;
    logic [OB_AW-1:0]  off_wb_addr_reg, off_wb_addr_next;
    logic [VAL_W-1:0]  res_reg, res_next;
    logic [VAL_W-1:0]  m_sum_reg, m_sum_next;

    logic              s_accept;
    logic              pos_ok;
    logic [POS_W-1:0]  pos_m1;
    logic [31:0]       n_lim;
    logic [BASE_W-1:0] last_pos;
    logic [OB_CW-1:0]  ob_inc;
    logic [BASE_W-1:0] base_inc;
    logic              off_go;
    logic              off_more;

    logic              div_start;
    div_res_t          div_res;

    logic              ps_we, off_we;
    logic [PS_AW-1:0]  ps_waddr;
    logic [OB_AW-1:0]  off_waddr;
    logic [VAL_W-1:0]  ps_wdata, off_wdata;
    logic [VAL_W-1:0]  ps_rdata, off_rdata;
    logic              clearing;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign pos_ok   = (s_position != '0) && (32'(s_position) <= CAP32);
    assign pos_m1   = pos_reg - POS_ONE;
    assign clearing = (state_reg == S_CLEAR);

    // Saturate positions_in_use to 1..capacity; blocks whose first position
    // lies at or below last_pos are in use.
    always_comb begin
        n_lim = 32'(cfg_reg);
        if (n_lim == 32'd0) begin
            n_lim = 32'd1;
        end
        if (n_lim > CAP32) begin
            n_lim = CAP32;
        end
    end
    assign last_pos = BASE_W'(n_lim - 32'd1);

    // base_reg holds the 0-based first position of block ob_cnt_reg.
    assign ob_inc   = ob_cnt_reg + OB_ONE;
    assign base_inc = base_reg + BS_B;
    assign off_go   = (ob_cnt_reg < NB_C) && (base_reg <= last_pos);
    assign off_more = (ob_inc < NB_C) && (base_inc <= last_pos);

    assign div_start = s_accept && pos_ok;

    bmps_div #(
        .DIVISOR (BLOCK_SIZE)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_position - POS_ONE),
        .res      (div_res)
    );

    always_comb begin
        state_next       = state_reg;
        cfg_next         = cfg_wr_en ? cfg_wr_data : cfg_reg;
        clr_cnt_next     = clr_cnt_reg;
        ps_wb_next       = 1'b0;
        off_wb_next      = 1'b0;
        m_valid_next     = m_valid_reg;
        mode_next        = mode_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        ps_addr_next     = ps_addr_reg;
        idx_next         = idx_reg;
        ob_cnt_next      = ob_cnt_reg;
        base_next        = base_reg;
        ps_wb_addr_next  = ps_wb_addr_reg;
        off_wb_addr_next = off_wb_addr_reg;
        res_next         = res_reg;
        m_sum_next       = m_sum_reg;

        // Drop the result once the receiver takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + PS_ONE;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    mode_next    = s_mode;
                    pos_next     = s_position;
                    val_next     = mod_reduce(s_value);
                    ps_addr_next = PS_AW'(s_position - POS_ONE);
                    if (pos_ok) begin
                        state_next = S_DIV;
                    end else if (s_mode == MODE_QUERY) begin
                        res_next   = '0;
                        state_next = S_QOUT;
                    end
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    if (mode_reg == MODE_ADD) begin
                        idx_next    = div_res.rem;
                        ob_cnt_next = OB_CW'(div_res.quot) + OB_ONE;
                        base_next   = BASE_W'(pos_m1) - BASE_W'(div_res.rem) + BS_B;
                        state_next  = S_APS;
                    end else begin
                        ob_cnt_next = OB_CW'(div_res.quot);
                        state_next  = S_QRD;
                    end
                end
            end
            S_QRD: begin
                state_next = S_QSUM;
            end
            S_QSUM: begin
                res_next   = mod_add(off_rdata, ps_rdata);
                state_next = S_QOUT;
            end
            S_QOUT: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = res_reg;
                    state_next   = S_IDLE;
                end
            end
            S_APS: begin
                // Read this entry now, write it back next cycle.
                ps_wb_next      = 1'b1;
                ps_wb_addr_next = ps_addr_reg;
                ps_addr_next    = ps_addr_reg + PS_ONE;
                idx_next        = idx_reg + POS_ONE;
                if (idx_reg == IDX_LAST) begin
                    state_next = off_go ? S_AOFF : S_DRAIN;
                end
            end
            S_AOFF: begin
                off_wb_next      = 1'b1;
                off_wb_addr_next = ob_cnt_reg[OB_AW-1:0];
                ob_cnt_next      = ob_inc;
                base_next        = base_inc;
                if (!off_more) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory ports: the clearing pass owns the write ports after reset.
    assign ps_we     = clearing || ps_wb_reg;
    assign ps_waddr  = clearing ? clr_cnt_reg : ps_wb_addr_reg;
    assign ps_wdata  = clearing ? '0 : mod_add(ps_rdata, val_reg);
    assign off_we    = clearing ? (32'(clr_cnt_reg) < NB32) : off_wb_reg;
    assign off_waddr = clearing ? clr_cnt_reg[OB_AW-1:0] : off_wb_addr_reg;
    assign off_wdata = clearing ? '0 : mod_add(off_rdata, val_reg);

    bmps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAP)
    ) u_partial_ram (
        .aclk  (aclk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (ps_wdata),
        .raddr (ps_addr_reg),
        .rdata (ps_rdata)
    );

    bmps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_BLOCKS)
    ) u_offset_ram (
        .aclk  (aclk),
        .we    (off_we),
        .waddr (off_waddr),
        .wdata (off_wdata),
        .raddr (ob_cnt_reg[OB_AW-1:0]),
        .rdata (off_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cfg_reg     <= POS_W'(CFG_RESET);
            clr_cnt_reg <= '0;
            ps_wb_reg   <= 1'b0;
            off_wb_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            clr_cnt_reg <= clr_cnt_next;
            ps_wb_reg   <= ps_wb_next;
            off_wb_reg  <= off_wb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        ps_addr_reg     <= ps_addr_next;
        idx_reg         <= idx_next;
        ob_cnt_reg      <= ob_cnt_next;
        base_reg        <= base_next;
        ps_wb_addr_reg  <= ps_wb_addr_next;
        off_wb_addr_reg <= off_wb_addr_next;
        res_reg         <= res_next;
        m_sum_reg       <= m_sum_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_prefix_sum = m_sum_reg;

endmodule

`default_nettype wire

[src/bmps_checker.sv]
`default_nettype none
`include "blocked_modular_prefix_sum_assert.svh"

module bmps_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       s_mode,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [bmps_pkg::VAL_W-1:0] m_prefix_sum
);

    import bmps_pkg::*;

    // A stalled result holds.
    `BMPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                      m_valid && $stable(m_prefix_sum))
    // Results are always reduced below the prime.
    `BMPS_ASSERT_IMPLY(a_out_range, aclk, aresetn, m_valid, m_prefix_sum < PRIME)
    // One item at a time: ready drops right after an accepted query transaction.
    `BMPS_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready && s_mode, !s_ready)
    // A result appears only at the end of a busy period.
    `BMPS_ASSERT_IMPLY(a_out_after_work, aclk, aresetn, $rose(m_valid), $past(!s_ready))
    // Reset empties the output and starts the clearing pass.
    `BMPS_ASSERT_NEXT(a_reset_quiet, aclk, 1'b1, !aresetn, !m_valid && !s_ready)

endmodule

bind blocked_modular_prefix_sum bmps_checker u_bmps_checker (.*);

`default_nettype wire

[test/tb.sv]
`default_nettype none

module tb;

    import bmps_pkg::*;

    // Geometry of the block under test; the testbench uses the default sizes.
    localparam int BLOCK_SIZE   = BLOCK_SIZE_DEF;
    localparam int NUM_BLOCKS   = NUM_BLOCKS_DEF;
    localparam int CAPACITY     = BLOCK_SIZE * NUM_BLOCKS;
    localparam int PS_IW        = $clog2(CAPACITY);
    localparam int OB_IW        = $clog2(NUM_BLOCKS);
    localparam int POS_MAX      = (1 << POS_W) - 1;
    localparam int VAL_MAX      = (1 << VAL_W) - 1;
    localparam longint unsigned MODULUS = 64'd1000000007;

    // Twice the longest add walk. Adds give no transaction, so wait out this
    // margin before touching the register.
    localparam int ADD_SETTLE   = 2 * (3 + BLOCK_SIZE + NUM_BLOCKS);
    // Clearing pass, 543 items at their slowest, long sender gaps and long
    // receiver stalls, several times over.
    localparam int RUN_LIMIT    = 1000000;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] sum;
    } pending_sum_t;

    // DUT ports; the inputs are driven to known values from time zero.
    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             cfg_wr_en    = 1'b0;
    logic [POS_W-1:0] cfg_wr_data  = '0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic             s_mode       = 1'b0;
    logic [POS_W-1:0] s_position   = '0;
    logic [VAL_W-1:0] s_value      = '0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic [VAL_W-1:0] m_prefix_sum;

    // Shadow of the block's store and its register.
    logic [VAL_W-1:0] block_offset_m [NUM_BLOCKS] = '{default: '0};
    logic [VAL_W-1:0] run_sum_m      [CAPACITY]   = '{default: '0};
    logic [POS_W-1:0] positions_reg  = POS_W'(CFG_RESET);

    // Prefix sums still owed by the block, oldest first.
    pending_sum_t     pending_sums[$];

    int               mismatches     = 0;
    int               cycle_count    = 0;
    int               send_idle_pct  = 0;
    int               ready_stall_pct = 0;

    blocked_modular_prefix_sum u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prefix_sum (m_prefix_sum)
    );

    always #4 aclk = ~aclk;

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("blocked_modular_prefix_sum test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Sum modulo the prime, done in wide integers.
    function automatic logic [VAL_W-1:0] add_mod_prime(input logic [VAL_W-1:0] a,
                                                       input logic [VAL_W-1:0] b);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        return VAL_W'(s % MODULUS);
    endfunction

    // Advance the shadow store by one accepted transaction. A query queues the
    // prefix sum it must return; an add updates in-block sums and offsets.
    task automatic apply_transaction(input op_t op, input logic [POS_W-1:0] pos,
                                     input logic [VAL_W-1:0] val);
        int unsigned  blk;
        int unsigned  idx;
        int unsigned  span;
        int unsigned  used_blocks;
        bit           in_range;
        logic [VAL_W-1:0] amount;
        pending_sum_t owed;

        in_range = (pos >= 1) && (pos <= CAPACITY);
        blk = in_range ? (pos - 1) / BLOCK_SIZE : 0;
        idx = in_range ? (pos - 1) % BLOCK_SIZE : 0;

        if (op == OP_QUERY) begin
            owed.pos = pos;
            owed.sum = '0;
            if (in_range) begin
                owed.sum = add_mod_prime(block_offset_m[OB_IW'(blk)],
                                         run_sum_m[PS_IW'(blk * BLOCK_SIZE + idx)]);
            end
            pending_sums.insert(pending_sums.size(), owed);
        end else if (in_range) begin
            // Values at or above the prime are folded back first.
            amount = VAL_W'(longint'(val) % MODULUS);
            for (int unsigned i = idx; i < BLOCK_SIZE; i++) begin
                run_sum_m[PS_IW'(blk * BLOCK_SIZE + i)] =
                    add_mod_prime(run_sum_m[PS_IW'(blk * BLOCK_SIZE + i)], amount);
            end
            // Zero counts as one position; anything past capacity saturates.
            span = 32'(positions_reg);
            if (span == 0) span = 1;
            if (span > CAPACITY) span = CAPACITY;
            used_blocks = (span - 1) / BLOCK_SIZE + 1;
            for (int unsigned b = blk + 1; b < used_blocks; b++) begin
                block_offset_m[OB_IW'(b)] = add_mod_prime(block_offset_m[OB_IW'(b)], amount);
            end
        end
    endtask

    // Present one item and hold it until the transaction completes. Valid
    // stays high on return so that a back-to-back item never drops it.
    task automatic send_item(input op_t op, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        s_valid    <= 1'b1;
        s_mode     <= op;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        apply_transaction(op, pos, val);
    endtask

    // Idle the sender for a random number of cycles per the current phase.
    task automatic sender_gap();
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Hold off the sender until every owed prefix sum has arrived, then let
    // any trailing add finish its walk.
    task automatic pause_until_drained(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_positions_in_use(input logic [POS_W-1:0] count);
        pause_until_drained(ADD_SETTLE);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        positions_reg = count;
    endtask

    // Random item, weighted toward valid positions and block boundaries, with
    // some position zero, positions past capacity and values past the prime.
    task automatic send_random_item();
        op_t              op;
        int unsigned      sel;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;

        op  = $urandom_range(1) ? OP_QUERY : OP_ADD;
        sel = $urandom_range(99);
        if (sel < 6)
            pos = '0;
        else if (sel < 14)
            pos = POS_W'($urandom_range(CAPACITY + 1, POS_MAX));
        else if (sel < 32)
            pos = POS_W'($urandom_range(0, NUM_BLOCKS - 1) * BLOCK_SIZE +
                         ($urandom_range(1) ? 1 : BLOCK_SIZE));
        else
            pos = POS_W'($urandom_range(1, CAPACITY));

        sel = $urandom_range(99);
        if (sel < 5)
            val = '0;
        else if (sel < 10)
            val = '1;
        else if (sel < 25)
            val = VAL_W'($urandom_range(32'(MODULUS), VAL_MAX));
        else
            val = VAL_W'($urandom_range(0, 32'(MODULUS - 1)));

        sender_gap();
        send_item(op, pos, val);
    endtask

    // Compare each prefix sum taken by the receiver, then pick the next ready.
    always @(posedge aclk) begin : check_results
        pending_sum_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("prefix sum %0d with none owed", m_prefix_sum));
            end else begin
                want = pending_sums.pop_front();
                if (m_prefix_sum !== want.sum) begin
                    report_mismatch($sformatf("position %0d: prefix sum %0d, want %0d",
                                              want.pos, m_prefix_sum, want.sum));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Boundaries, zero and out-of-range positions, value folding, and the
    // ignored value of a query, at the reset register value.
    task automatic test_directed();
        send_item(OP_QUERY, POS_W'(0), '1);
        send_item(OP_QUERY, POS_W'(1), VAL_W'(0));
        send_item(OP_QUERY, POS_W'(POS_MAX), VAL_W'(0));
        send_item(OP_ADD, POS_W'(1), VAL_W'(MODULUS));
        send_item(OP_QUERY, POS_W'(1), VAL_W'(0));
        send_item(OP_ADD, POS_W'(1), '1);
        send_item(OP_ADD, POS_W'(0), VAL_W'(12345));
        send_item(OP_ADD, POS_W'(CAPACITY + 1), VAL_W'(99));
        send_item(OP_ADD, POS_W'(POS_MAX), '1);
        send_item(OP_ADD, POS_W'(BLOCK_SIZE), VAL_W'(MODULUS - 1));
        send_item(OP_ADD, POS_W'(BLOCK_SIZE + 1), VAL_W'(1));
        send_item(OP_ADD, POS_W'(CAPACITY), VAL_W'(500));
        send_item(OP_ADD, POS_W'(CAPACITY - BLOCK_SIZE + 1), VAL_W'(7));
        send_item(OP_QUERY, POS_W'(1), VAL_W'(0));
        send_item(OP_QUERY, POS_W'(BLOCK_SIZE - 1), VAL_W'(0));
        send_item(OP_QUERY, POS_W'(BLOCK_SIZE), VAL_W'(0));
        send_item(OP_QUERY, POS_W'(BLOCK_SIZE + 1), VAL_W'(0));
        send_item(OP_QUERY, POS_W'(CAPACITY - BLOCK_SIZE), VAL_W'(0));
        send_item(OP_QUERY, POS_W'(CAPACITY - BLOCK_SIZE + 1), VAL_W'(0));
        send_item(OP_QUERY, POS_W'(CAPACITY), VAL_W'(0));
        send_item(OP_QUERY, POS_W'(CAPACITY + 1), VAL_W'(0));
        send_item(OP_QUERY, POS_W'(CAPACITY / 2), '1);
        send_item(OP_QUERY, POS_W'(0), VAL_W'(0));
    endtask

    // Walk the register through its extremes and a few block edges; each
    // setting gets a burst of random traffic under a rotating idle pattern.
    task automatic test_register_sweep();
        logic [POS_W-1:0] settings[10];
        settings = '{POS_W'(0), POS_W'(1), POS_W'(BLOCK_SIZE - 1), POS_W'(BLOCK_SIZE),
                     POS_W'(BLOCK_SIZE + 1), POS_W'(CAPACITY - 1), POS_W'(CAPACITY),
                     POS_W'(CAPACITY + 1), POS_W'(POS_MAX),
                     POS_W'($urandom_range(0, POS_MAX))};
        foreach (settings[k]) begin
            write_positions_in_use(settings[k]);
            send_idle_pct   = (k % 3 == 1) ? 29 : 0;
            ready_stall_pct = (k % 3 == 2) ? 29 : 0;
            repeat (18) send_random_item();
        end
    endtask

    // One idle pattern, one random register value, n random items. Optionally
    // stop the sender halfway until everything owed has come back.
    task automatic test_idle_phase(input int send_pct, input int stall_pct,
                                   input int n_items, input bit drain_midway);
        write_positions_in_use(POS_W'($urandom_range(0, POS_MAX)));
        send_idle_pct   = send_pct;
        ready_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            if (drain_midway && i == n_items / 2) pause_until_drained(0);
            send_random_item();
        end
    endtask

    initial begin
        // Reset is synchronous; the block then clears its store before ready.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_register_sweep();
        test_idle_phase(0, 0, 90, 1'b0);
        test_idle_phase(88, 0, 70, 1'b0);
        test_idle_phase(0, 88, 70, 1'b0);
        test_idle_phase(29, 29, 110, 1'b1);

        // Drop valid, collect everything owed, then let a last add settle.
        pause_until_drained(ADD_SETTLE);

        if (mismatches == 0 && pending_sums.size() == 0) begin
            $display("blocked_modular_prefix_sum test passed");
        end else begin
            $display("blocked_modular_prefix_sum test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
